// ===== rtl/mbce_pkg.sv =====
// Package for the masked base64 encoder: constants, job record and character helpers.
package mbce_pkg;

   // Key mask geometry
   localparam int KeyBytes  = 64;
   localparam int KeyPosW   = $clog2(KeyBytes);
   localparam int MaskWords = 8;
   localparam int MaskIdxW  = $clog2(MaskWords);
   localparam int MaskW     = 64;

   // CRC-32, reflected
   localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
   localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

   // Sextet codes that need an escape pair
   localparam logic [5:0] SextY     = 6'd50;
   localparam logic [5:0] SextPlus  = 6'd62;
   localparam logic [5:0] SextSlash = 6'd63;

   // Trailing padding kind of a job
   localparam logic [1:0] PadNone = 2'd0;
   localparam logic [1:0] PadTwo  = 2'd1;
   localparam logic [1:0] PadOne  = 2'd2;

   // ASCII characters used by the escapes and the suffix
   localparam logic [6:0] ChY     = 7'h79;  // y
   localparam logic [6:0] ChBigK  = 7'h4B;  // K
   localparam logic [6:0] ChP     = 7'h70;  // p
   localparam logic [6:0] ChBigS  = 7'h53;  // S
   localparam logic [6:0] ChJ     = 7'h6A;  // j
   localparam logic [6:0] ChQ     = 7'h71;  // q
   localparam logic [6:0] ChG     = 7'h67;  // g

   // One unit of output work: up to four sextets, padding and suffix flag
   typedef struct packed {
      logic [3:0][5:0] sext;
      logic [2:0]      n_sext;
      logic [1:0]      pad;
      logic            last;
   } job_type;

   // Standard base64 alphabet
   function automatic logic [6:0] b64_char(input logic [5:0] v);
      logic [6:0] ch;
      if (v < 6'd26) begin
         ch = 7'h41 + {1'b0, v};
      end else if (v < 6'd52) begin
         ch = 7'h61 + {1'b0, v - 6'd26};
      end else if (v < 6'd62) begin
         ch = 7'h30 + {1'b0, v - 6'd52};
      end else if (v == SextPlus) begin
         ch = 7'h2B;
      end else begin
         ch = 7'h2F;
      end
      return ch;
   endfunction

   function automatic logic needs_escape(input logic [5:0] v);
      return (v == SextY) || (v == SextPlus) || (v == SextSlash);
   endfunction

   // Second character of an escape pair
   function automatic logic [6:0] escape_char(input logic [5:0] v);
      logic [6:0] ch;
      if (v == SextY) begin
         ch = ChBigK;
      end else if (v == SextPlus) begin
         ch = ChP;
      end else begin
         ch = ChBigS;
      end
      return ch;
   endfunction

   // Lower-case hex digit
   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] ch;
      if (nib < 4'd10) begin
         ch = 7'h30 + {3'b000, nib};
      end else begin
         ch = 7'h61 + {3'b000, nib - 4'd10};
      end
      return ch;
   endfunction

   // Fold one character into the reflected CRC
   function automatic logic [31:0] crc_char(input logic [31:0] crc, input logic [6:0] ch);
      logic [31:0] c;
      c = crc ^ {25'd0, ch};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/masked_base64_crc_encoder.sv =====
// Masked base64 encoder with escaping and a CRC-32 hex suffix per message.
// The characters of an item pass the input job register, the emitter job register and the output register.
// Throughput: one character per cycle through the output register while the result stream is
// not stalled; a byte yields 0 to 17 characters. A byte is taken every cycle while the input
// job register has room.
// Reset: synchronous; clears stream state, mask words to zero and the CRC to all ones.
module masked_base64_crc_encoder (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [6:0] out_char, [7] zero
   output logic        rsp_tlast,   // end_of_text
   // configuration
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   // Emitter phases
   localparam logic [2:0] PH_SEXT = 3'd0;
   localparam logic [2:0] PH_PAD0 = 3'd1;
   localparam logic [2:0] PH_PAD1 = 3'd2;
   localparam logic [2:0] PH_G    = 3'd3;
   localparam logic [2:0] PH_HEX  = 3'd4;

   logic [mbce_pkg::MaskW-1:0] mask_ff [mbce_pkg::MaskWords];

   logic [mbce_pkg::KeyPosW-1:0] key_pos_ff, key_pos_in;
   logic [15:0]       gbytes_ff, gbytes_in;
   logic [1:0]        gcount_ff, gcount_in;

   mbce_pkg::job_type s1_job_ff, s1_job_in;
   logic              s1_valid_ff, s1_valid_in;

   mbce_pkg::job_type job_ff;
   logic              job_valid_ff, job_valid_in;
   logic [2:0]        phase_ff, phase_in;
   logic [1:0]        sext_idx_ff, sext_idx_in;
   logic              esc_ff, esc_in;
   logic [2:0]        hex_idx_ff, hex_idx_in;
   logic [31:0]       crc_ff, crc_in;

   logic [6:0]        rsp_char_ff;
   logic              rsp_last_ff, rsp_valid_ff;

   logic              req_accept, s1_take, job_load, fire, job_end;
   logic [7:0]        key_byte, mbyte, b0, b1;
   logic [5:0]        cur_sext;
   logic [6:0]        cur_char;
   logic              cur_eot, crc_step;
   logic [31:0]       check;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < mbce_pkg::MaskWords; w++) begin
            mask_ff[w] <= '0;
         end
      end else if (csr_we) begin
         mask_ff[csr_index[mbce_pkg::MaskIdxW-1:0]] <= csr_wdata;
      end
   end

   // Handshakes
   assign fire       = job_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign job_load   = s1_valid_ff && (!job_valid_ff || job_end);
   assign s1_take    = job_load;
   assign req_tready = !s1_valid_ff || s1_take;
   assign req_accept = req_tvalid && req_tready;

   // Mask the byte and group it into base64 jobs
   always_comb begin
      key_byte = mask_ff[key_pos_ff[mbce_pkg::KeyPosW-1:3]][{key_pos_ff[2:0], 3'b000} +: 8];
      mbyte    = req_tdata ^ key_byte;
      key_pos_in  = key_pos_ff;
      gbytes_in   = gbytes_ff;
      gcount_in   = gcount_ff;
      s1_job_in   = s1_job_ff;
      s1_valid_in = s1_take ? 1'b0 : s1_valid_ff;
      b0 = (gcount_ff == 2'd0) ? mbyte : gbytes_ff[7:0];
      b1 = (gcount_ff == 2'd1) ? mbyte : gbytes_ff[15:8];
      if (req_accept) begin
         if (req_tlast ||
             key_pos_ff == mbce_pkg::KeyPosW'(mbce_pkg::KeyBytes - 1)) begin
            key_pos_in = '0;
         end else begin
            key_pos_in = key_pos_ff + mbce_pkg::KeyPosW'(1);
         end
         s1_job_in.last = req_tlast;
         if (gcount_ff == 2'd2) begin
            // full group of three
            s1_job_in.sext[0] = b0[7:2];
            s1_job_in.sext[1] = {b0[1:0], b1[7:4]};
            s1_job_in.sext[2] = {b1[3:0], mbyte[7:6]};
            s1_job_in.sext[3] = mbyte[5:0];
            s1_job_in.n_sext  = 3'd4;
            s1_job_in.pad     = mbce_pkg::PadNone;
            s1_valid_in = 1'b1;
            gbytes_in   = '0;
            gcount_in   = 2'd0;
         end else begin
            gbytes_in = {b1, b0};
            gcount_in = gcount_ff + 2'd1;
            // partial group closed by the final byte
            s1_job_in.sext[0] = b0[7:2];
            s1_job_in.sext[1] = {b0[1:0], (gcount_ff == 2'd1) ? b1[7:4] : 4'd0};
            s1_job_in.sext[2] = {b1[3:0], 2'b00};
            s1_job_in.sext[3] = '0;
            if (gcount_ff == 2'd0) begin
               s1_job_in.n_sext = 3'd2;
               s1_job_in.pad    = mbce_pkg::PadTwo;
            end else begin
               s1_job_in.n_sext = 3'd3;
               s1_job_in.pad    = mbce_pkg::PadOne;
            end
            if (req_tlast) begin
               s1_valid_in = 1'b1;
            end
         end
         if (req_tlast) begin
            gbytes_in = '0;
            gcount_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_pos_ff  <= '0;
         gbytes_ff   <= '0;
         gcount_ff   <= 2'd0;
         s1_valid_ff <= 1'b0;
      end else begin
         key_pos_ff  <= key_pos_in;
         gbytes_ff   <= gbytes_in;
         gcount_ff   <= gcount_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_job_ff <= s1_job_in;
   end

   // Emitter: one character per fired cycle
   always_comb begin
      cur_sext    = job_ff.sext[sext_idx_ff];
      check       = ~crc_ff;
      cur_char    = mbce_pkg::b64_char(cur_sext);
      cur_eot     = 1'b0;
      crc_step    = 1'b0;
      job_end     = 1'b0;
      phase_in    = phase_ff;
      sext_idx_in = sext_idx_ff;
      esc_in      = esc_ff;
      hex_idx_in  = hex_idx_ff;
      unique case (phase_ff)
         PH_SEXT: begin
            crc_step = 1'b1;
            if (!esc_ff && mbce_pkg::needs_escape(cur_sext)) begin
               cur_char = mbce_pkg::ChY;
               esc_in   = 1'b1;
            end else begin
               if (esc_ff) begin
                  cur_char = mbce_pkg::escape_char(cur_sext);
               end
               esc_in      = 1'b0;
               sext_idx_in = sext_idx_ff + 2'd1;
               if ({1'b0, sext_idx_ff} == job_ff.n_sext - 3'd1) begin
                  if (job_ff.pad != mbce_pkg::PadNone) begin
                     phase_in = PH_PAD0;
                  end else if (job_ff.last) begin
                     phase_in = PH_G;
                  end else begin
                     job_end = 1'b1;
                  end
               end
            end
         end
         PH_PAD0: begin
            crc_step = 1'b1;
            cur_char = mbce_pkg::ChY;
            phase_in = PH_PAD1;
         end
         PH_PAD1: begin
            crc_step = 1'b1;
            cur_char = (job_ff.pad == mbce_pkg::PadTwo) ? mbce_pkg::ChJ : mbce_pkg::ChQ;
            phase_in = PH_G;
         end
         PH_G: begin
            cur_char   = mbce_pkg::ChG;
            phase_in   = PH_HEX;
            hex_idx_in = 3'd0;
         end
         PH_HEX: begin
            cur_char   = mbce_pkg::hex_char(check[{3'd7 - hex_idx_ff, 2'b00} +: 4]);
            hex_idx_in = hex_idx_ff + 3'd1;
            if (hex_idx_ff == 3'd7) begin
               cur_eot = 1'b1;
               job_end = 1'b1;
            end
         end
         default: begin
            job_end = 1'b1;
         end
      endcase
      // gate the step with the output handshake
      if (!fire) begin
         job_end     = 1'b0;
         phase_in    = phase_ff;
         sext_idx_in = sext_idx_ff;
         esc_in      = esc_ff;
         hex_idx_in  = hex_idx_ff;
      end
      crc_in = crc_ff;
      if (fire && crc_step) begin
         crc_in = mbce_pkg::crc_char(crc_ff, cur_char);
      end else if (fire && cur_eot) begin
         crc_in = mbce_pkg::CrcInit;
      end
      job_valid_in = job_load ? 1'b1 : (job_end ? 1'b0 : job_valid_ff);
      if (job_load) begin
         phase_in    = PH_SEXT;
         sext_idx_in = 2'd0;
         esc_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         phase_ff     <= PH_SEXT;
         sext_idx_ff  <= 2'd0;
         esc_ff       <= 1'b0;
         hex_idx_ff   <= 3'd0;
         crc_ff       <= mbce_pkg::CrcInit;
      end else begin
         job_valid_ff <= job_valid_in;
         phase_ff     <= phase_in;
         sext_idx_ff  <= sext_idx_in;
         esc_ff       <= esc_in;
         hex_idx_ff   <= hex_idx_in;
         crc_ff       <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_load) begin
         job_ff <= s1_job_ff;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_char_ff <= cur_char;
         rsp_last_ff <= cur_eot;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   // CRC restarts once the last hex digit of a suffix leaves the emitter
   a_crc_restart: assert property (@(posedge clock) disable iff (reset)
      fire && phase_ff == PH_HEX && hex_idx_ff == 3'd7 |=> crc_ff == mbce_pkg::CrcInit)
      else $error("CRC not restarted after suffix");

   // A held job always carries at least two sextets
   a_job_len: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> (job_ff.n_sext == 3'd2 || job_ff.n_sext == 3'd3 ||
                        job_ff.n_sext == 3'd4))
      else $error("malformed job");

   // A pending job that is not handed on blocks new bytes
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_take |-> !req_tready)
      else $error("job register overwritten");

   // Result register is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid after reset");
`endif

endmodule
